>>> rtl/multi_channel_tick_timer_assert.svh
// assertion macros used by the timer controller
`ifndef MULTI_CHANNEL_TICK_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_TICK_TIMER_ASSERT_SVH

// checked on every clock edge outside reset
`define MCTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define MCTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/mctt_pkg.sv
// types and constants of the multi-channel tick timer
`default_nettype none

package mctt_pkg;

  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned TICK_W   = 31;
  localparam int unsigned PERIOD_W = 31;
  localparam int unsigned WAIT_W   = 34;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SPIN_W   = 3;

  localparam logic [SPIN_W-1:0] SPIN_LIMIT = 3'd4;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  localparam logic KIND_FIRE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                command;
    logic [CHAN_W-1:0]   channel;
    logic [TICK_W-1:0]   elapsed_ticks;
    logic [TICK_W-1:0]   start_wait;
    logic [PERIOD_W-1:0] reload_interval;
    logic                notify;
    logic                enable;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [CHAN_W-1:0]  fired_channel;
    logic [COUNT_W-1:0] backlog_count;
    logic [COUNT_W-1:0] free_running;
    logic               spin_yield;
    logic               spin_warning;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transaction taken
    logic start;    // subtract ticks from the current channel
    logic step;     // one reload iteration on the current channel
    logic summary;  // load the completion item
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic wait_pos;
    logic one_shot;
    logic need_emit;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/multi_channel_tick_timer.sv
// arm: the sequencer moves to ST_SUM and registers the summary once the output is free
// tick: idle channels are skipped; each active channel gets a subtract, up to three reloads
// and an exit check (a one-shot reloads at most once), and the walk waits while the output is stalled
// one command is in flight at a time; the next is taken once its summary is registered
// reset clears every channel, the free-running count and the spin counter
`default_nettype none

module multi_channel_tick_timer import mctt_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  ctl_cmd_t      cmd;
  dp_status_t    status;
  logic [IW-1:0] idx;

  mctt_controller #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .IW          (IW)
  ) u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_item_i.command),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  mctt_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .IW          (IW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/mctt_datapath.sv
// channel table, counters, reload arithmetic and output register
`default_nettype none

module mctt_datapath import mctt_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned IW           = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire in_item_t        in_item_i,
  input  wire ctl_cmd_t        cmd_i,
  input  wire logic [IW-1:0]   idx_i,
  output dp_status_t           status_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output out_item_t            out_item_o
);

  localparam int unsigned XW = (IW > CHAN_W) ? IW : CHAN_W;

  logic signed [WAIT_W-1:0] wait_q [NUM_CHANNELS];
  logic [PERIOD_W-1:0]      period_q [NUM_CHANNELS];
  logic [COUNT_W-1:0]       backlog_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  notify_q, active_q;

  logic [COUNT_W-1:0] free_run_q;
  logic [SPIN_W-1:0]  spin_q, spin_d;
  logic [TICK_W-1:0]  ticks_q;
  logic               yield_q, warn_q, yield_d, warn_d;
  logic               saved_pos_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic                     is_arm, arm_we;
  logic [XW-1:0]            chan_x;
  logic [IW-1:0]            arm_idx;
  logic signed [WAIT_W-1:0] cur_wait, cur_iv, sub_wait, add_wait, step_wait;
  logic                     clamp;
  logic [COUNT_W-1:0]       step_backlog;
  logic                     out_free;

  assign is_arm  = (in_item_i.command == CMD_ARM);
  assign chan_x  = XW'(in_item_i.channel);
  assign arm_idx = chan_x[IW-1:0];
  assign arm_we  = cmd_i.accept && is_arm && (32'(in_item_i.channel) < NUM_CHANNELS);

  assign cur_wait = wait_q[idx_i];
  assign cur_iv   = $signed({{(WAIT_W-PERIOD_W){1'b0}}, period_q[idx_i]});
  assign sub_wait = cur_wait - $signed({{(WAIT_W-TICK_W){1'b0}}, ticks_q});
  assign add_wait = cur_wait + cur_iv;
  // backlog larger than one period is clamped and counted
  assign clamp        = add_wait < -cur_iv;
  assign step_wait    = clamp ? -cur_iv : add_wait;
  assign step_backlog = clamp ? backlog_q[idx_i] + COUNT_W'(1) : backlog_q[idx_i];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.active    = active_q[idx_i];
    status_o.wait_pos  = cur_wait > 0;
    status_o.one_shot  = (period_q[idx_i] == '0);
    status_o.need_emit = saved_pos_q && notify_q[idx_i];
    status_o.out_free  = out_free;
  end

  // zero-tick spin detector
  always_comb begin
    spin_d  = spin_q;
    yield_d = 1'b0;
    warn_d  = 1'b0;
    if (in_item_i.elapsed_ticks != '0) begin
      spin_d = '0;
    end else if (spin_q < SPIN_LIMIT) begin
      spin_d = spin_q + SPIN_W'(1);
    end else begin
      yield_d = 1'b1;
      if (spin_q == SPIN_LIMIT) begin
        spin_d = spin_q + SPIN_W'(1);
        warn_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wait_q[i]    <= '0;
        period_q[i]  <= '0;
        backlog_q[i] <= '0;
      end
      notify_q <= '0;
      active_q <= '0;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (arm_we && arm_idx == IW'(i)) begin
          wait_q[i]   <= $signed({{(WAIT_W-TICK_W){1'b0}}, in_item_i.start_wait});
          period_q[i] <= in_item_i.reload_interval;
          notify_q[i] <= in_item_i.notify;
          active_q[i] <= in_item_i.enable;
        end
        if (cmd_i.start && idx_i == IW'(i)) begin
          wait_q[i] <= sub_wait;
        end
        if (cmd_i.step && idx_i == IW'(i)) begin
          wait_q[i]    <= step_wait;
          backlog_q[i] <= step_backlog;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_run_q  <= '0;
      spin_q      <= '0;
      yield_q     <= 1'b0;
      warn_q      <= 1'b0;
      saved_pos_q <= 1'b0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        ticks_q <= in_item_i.elapsed_ticks;
        if (is_arm) begin
          yield_q <= 1'b0;
          warn_q  <= 1'b0;
        end else begin
          spin_q     <= spin_d;
          yield_q    <= yield_d;
          warn_q     <= warn_d;
          free_run_q <= free_run_q + COUNT_W'(in_item_i.elapsed_ticks);
        end
      end
      if (cmd_i.start) begin
        saved_pos_q <= cur_wait > 0;
      end
      if ((cmd_i.step && status_o.need_emit) || cmd_i.summary) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.summary) begin
      out_q.kind          <= KIND_SUMMARY;
      out_q.fired_channel <= '0;
      out_q.backlog_count <= '0;
      out_q.free_running  <= free_run_q;
      out_q.spin_yield    <= yield_q;
      out_q.spin_warning  <= warn_q;
      out_q.last          <= 1'b1;
    end else if (cmd_i.step && status_o.need_emit) begin
      out_q.kind          <= KIND_FIRE;
      out_q.fired_channel <= CHAN_W'(idx_i);
      out_q.backlog_count <= step_backlog;
      out_q.free_running  <= free_run_q;
      out_q.spin_yield    <= yield_q;
      out_q.spin_warning  <= warn_q;
      out_q.last          <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/mctt_controller.sv
// sequencer that walks the channel table for each command
`default_nettype none

`include "multi_channel_tick_timer_assert.svh"

module mctt_controller import mctt_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned IW           = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_command_i,
  output logic               in_ready_o,
  input  wire dp_status_t    status_i,
  output ctl_cmd_t           cmd_o,
  output logic [IW-1:0]      idx_o
);

  localparam int unsigned CW = $clog2(NUM_CHANNELS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign idx_o      = idx_q[IW-1:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          idx_d        = '0;
          state_d      = (in_command_i == CMD_ARM) ? ST_SUM : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (idx_q == CW'(NUM_CHANNELS)) begin
          state_d = ST_SUM;
        end else if (!status_i.active) begin
          idx_d = idx_q + CW'(1);
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_ITER;
        end
      end
      ST_ITER: begin
        if (status_i.wait_pos) begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_LOAD;
        end else if (!status_i.need_emit || status_i.out_free) begin
          cmd_o.step = 1'b1;
          // one-shot channels reload at most once per tick
          if (status_i.one_shot) begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.summary = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `MCTT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == ST_IDLE, "not idle after reset")
  `MCTT_ASSERT(a_iter_in_range, state_q == ST_ITER |-> idx_q < CW'(NUM_CHANNELS), "iter index out of range")
  `MCTT_ASSERT(a_step_not_pos, cmd_o.step |-> !status_i.wait_pos, "reload on positive wait")
  `MCTT_ASSERT(a_emit_free, (cmd_o.summary || (cmd_o.step && status_i.need_emit)) |-> status_i.out_free, "output overwritten")
  `MCTT_ASSERT(a_tick_walk, (in_valid_i && in_ready_o && in_command_i == CMD_TICK) |=> (state_q == ST_LOAD && idx_q == '0), "tick walk not started")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the multi-channel tick timer with its own timer-table model
`timescale 1ns / 1ps

module testbench;
  import mctt_pkg::*;

  localparam int NUM_CH = 16;
  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef logic signed [WAIT_W-1:0] wait_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  in_item_t  cmd_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_item;

  multi_channel_tick_timer #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_valid),
    .in_ready_o (cmd_ready),
    .in_item_i  (cmd_item),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_item_o (res_item)
  );

  always #2 clk_i = ~clk_i;

  // timer table as the block should hold it
  wait_t               chan_wait   [NUM_CH];
  logic [PERIOD_W-1:0] chan_period [NUM_CH];
  logic                chan_notify [NUM_CH];
  logic                chan_on     [NUM_CH];
  logic [COUNT_W-1:0]  chan_clamps [NUM_CH];
  logic [COUNT_W-1:0]  tick_total = '0;
  logic [SPIN_W-1:0]   zero_spins = '0;

  in_item_t  queued_cmds[$];
  out_item_t due_events[$];
  int        failures = 0;

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      chan_wait[i]   = '0;
      chan_period[i] = '0;
      chan_notify[i] = 1'b0;
      chan_on[i]     = 1'b0;
      chan_clamps[i] = '0;
    end
  end

  function automatic out_item_t make_event(logic kind, int ch, logic [COUNT_W-1:0] clamps,
                                           logic yield, logic warn, logic last);
    out_item_t r;
    r.kind          = kind;
    r.fired_channel = CHAN_W'(ch);
    r.backlog_count = clamps;
    r.free_running  = tick_total;
    r.spin_yield    = yield;
    r.spin_warning  = warn;
    r.last          = last;
    return r;
  endfunction

  task automatic advance_timers(in_item_t c);
    longint cur, prev, per;
    logic   yield, warn;
    yield = 1'b0;
    warn  = 1'b0;
    if (c.command == CMD_ARM) begin
      if (int'(c.channel) < NUM_CH) begin
        chan_wait[c.channel]   = wait_t'(c.start_wait);
        chan_period[c.channel] = c.reload_interval;
        chan_notify[c.channel] = c.notify;
        chan_on[c.channel]     = c.enable;
      end
      due_events.push_back(make_event(KIND_SUMMARY, 0, '0, 1'b0, 1'b0, 1'b1));
      return;
    end
    // zero-tick spin detector
    if (c.elapsed_ticks != '0) begin
      zero_spins = '0;
    end else if (zero_spins < SPIN_LIMIT) begin
      zero_spins++;
    end else begin
      yield = 1'b1;
      if (zero_spins == SPIN_LIMIT) begin
        zero_spins++;
        warn = 1'b1;
      end
    end
    tick_total = tick_total + COUNT_W'(c.elapsed_ticks);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (!chan_on[ch]) continue;
      per  = longint'(chan_period[ch]);
      prev = longint'(chan_wait[ch]);
      cur  = prev - longint'(c.elapsed_ticks);
      while (cur <= 0) begin
        cur += per;
        // backlog clamp: never more than one period behind
        if (cur < -per) begin
          chan_clamps[ch]++;
          cur = -per;
        end
        if (prev > 0 && chan_notify[ch])
          due_events.push_back(make_event(KIND_FIRE, ch, chan_clamps[ch], yield, warn, 1'b0));
        if (per <= 0) break;
      end
      chan_wait[ch] = wait_t'(cur);
    end
    due_events.push_back(make_event(KIND_SUMMARY, 0, '0, yield, warn, 1'b1));
  endtask

  function automatic int field_bad(string name, logic [COUNT_W-1:0] want,
                                   logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_event(out_item_t got);
    out_item_t want;
    if (due_events.size() == 0) begin
      $display("%0t: unexpected transaction, expected none got %p", $time, got);
      failures++;
      return;
    end
    want = due_events.pop_front();
    failures += field_bad("kind", COUNT_W'(want.kind), COUNT_W'(got.kind));
    failures += field_bad("fired_channel", COUNT_W'(want.fired_channel),
                          COUNT_W'(got.fired_channel));
    failures += field_bad("backlog_count", want.backlog_count, got.backlog_count);
    failures += field_bad("free_running", want.free_running, got.free_running);
    failures += field_bad("spin_yield", COUNT_W'(want.spin_yield), COUNT_W'(got.spin_yield));
    failures += field_bad("spin_warning", COUNT_W'(want.spin_warning),
                          COUNT_W'(got.spin_warning));
    failures += field_bad("last", COUNT_W'(want.last), COUNT_W'(got.last));
  endtask

  task automatic add_arm(int ch, logic [TICK_W-1:0] start, logic [PERIOD_W-1:0] period,
                         logic notify, logic enable);
    in_item_t c;
    c.command         = CMD_ARM;
    c.channel         = CHAN_W'(ch);
    c.elapsed_ticks   = TICK_W'($urandom);
    c.start_wait      = start;
    c.reload_interval = period;
    c.notify          = notify;
    c.enable          = enable;
    queued_cmds.push_back(c);
  endtask

  task automatic add_tick(logic [TICK_W-1:0] ticks);
    in_item_t c;
    c.command         = CMD_TICK;
    c.channel         = CHAN_W'($urandom);
    c.elapsed_ticks   = ticks;
    c.start_wait      = TICK_W'($urandom);
    c.reload_interval = PERIOD_W'($urandom);
    c.notify          = 1'($urandom);
    c.enable          = 1'($urandom);
    queued_cmds.push_back(c);
  endtask

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // driver
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_valid && cmd_ready) advance_timers(cmd_item);
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0 || queued_cmds.size() == 0) begin
          if (send_gap > 0) send_gap--;
          cmd_valid <= 1'b0;
        end else begin
          cmd_item  <= queued_cmds.pop_front();
          cmd_valid <= 1'b1;
          if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
          send_gap = draw_wait(send_burst);
        end
      end
    end
  end

  // monitor
  int recv_stall = 0;
  bit recv_burst = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid && res_ready) begin
        check_event(res_item);
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        recv_stall = draw_wait(recv_burst);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int made;
    int r;
    int zeros;
    // directed part
    add_tick('0);                           // zero tick with no channel armed
    add_arm(0, 5, 3, 1'b1, 1'b1);           // periodic
    add_arm(15, TICK_MAX, TICK_MAX, 1'b1, 1'b1);
    add_arm(7, 0, 0, 1'b1, 1'b1);           // one-shot already expired, only clamps
    add_arm(3, 10, 0, 1'b1, 1'b1);          // one-shot that fires once
    add_arm(4, 2, 1, 1'b0, 1'b1);           // silent channel
    add_arm(9, 1, 0, 1'b1, 1'b0);           // written but not serviced
    add_tick(1);
    add_tick(20);                           // backlog clamp on channel 0
    add_tick(TICK_MAX);
    for (int i = 0; i < 6; i++) add_tick('0);  // up to and past the spin limit
    add_tick(3);                            // spin counter clears
    add_arm(0, 0, 0, 1'b0, 1'b0);           // disarm
    add_arm(5, TICK_MAX, 0, 1'b1, 1'b1);
    add_arm(7, 4, 2, 1'b1, 1'b1);           // re-arm keeps the clamp count
    add_tick(5);
    add_tick(TICK_MAX);
    // random part
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 4) != 0)
          add_arm($urandom_range(0, NUM_CH - 1), TICK_W'($urandom_range(0, 60)),
                  ($urandom_range(0, 6) == 0) ? '0 : PERIOD_W'($urandom_range(1, 25)),
                  $urandom_range(0, 3) != 0, $urandom_range(0, 5) != 0);
        else
          add_arm($urandom_range(0, NUM_CH - 1), TICK_W'($urandom), PERIOD_W'($urandom),
                  1'($urandom), 1'($urandom));
        made++;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          zeros = $urandom_range(1, 7);
          for (int i = 0; i < zeros; i++) add_tick('0);
          made += zeros;
        end else begin
          add_tick((r < 4) ? TICK_W'($urandom) : TICK_W'($urandom_range(1, 40)));
          made++;
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (queued_cmds.size() != 0 || cmd_valid) @(posedge clk_i);
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
